[design/tilt_and_heading_angles_assert.svh]
// ----------------------------------------------------------------------------
// tilt and heading angles assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TILT_AND_HEADING_ANGLES_ASSERT_SVH
`define TILT_AND_HEADING_ANGLES_ASSERT_SVH

// condition in one cycle implies property in the next
`define TAH_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("tah assertion failed");

// condition implies property in the same cycle
`define TAH_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("tah assertion failed");

`endif

[design/tah_pkg.sv]
// ----------------------------------------------------------------------------
// tah_pkg
// shared constants, types and the cordic angle table
// ----------------------------------------------------------------------------
package tah_pkg;

	localparam int CORDIC_STAGES = 20;
	localparam int CORDIC_N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int NORM_N = 5;
	localparam int ROOT_N = 32;
	localparam int REM_W = 36;
	localparam int OP_W = 33;
	localparam int CW = 37;
	localparam int ZW = 26;
	localparam int LANE_LAT = NORM_N + CORDIC_N + 2;
	localparam int IN_W = 112;
	localparam int OUT_W = 32;
	localparam int LANES = 3;
	localparam int LANE_HEAD = 0;
	localparam int LANE_TX = 1;
	localparam int LANE_TY = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = 2;

	localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;
	localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;

	typedef struct packed {
		logic signed [OP_W-1:0] y;
		logic signed [OP_W-1:0] x;
	} pair_t;

	typedef pair_t [LANES-1:0] item_t;

	typedef struct packed {
		logic yz;
		logic xz;
		logic xn;
		logic yn;
	} flags_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		case (i)
			0: return 26'sd2949120;
			1: return 26'sd1740967;
			2: return 26'sd919879;
			3: return 26'sd466945;
			4: return 26'sd234379;
			5: return 26'sd117304;
			6: return 26'sd58666;
			7: return 26'sd29335;
			8: return 26'sd14668;
			9: return 26'sd7334;
			10: return 26'sd3667;
			11: return 26'sd1833;
			12: return 26'sd917;
			13: return 26'sd458;
			14: return 26'sd229;
			15: return 26'sd115;
			16: return 26'sd57;
			17: return 26'sd29;
			18: return 26'sd14;
			19: return 26'sd7;
			20: return 26'sd4;
			21: return 26'sd2;
			22: return 26'sd1;
			default: return 26'sd0;
		endcase
	endfunction

endpackage

[design/tah_front.sv]
// ----------------------------------------------------------------------------
// tah_front
// takes sample words, squares and sums accel terms, pipelined square roots,
// builds the three atan2 operand pairs
// ----------------------------------------------------------------------------
module tah_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tah_pkg::IN_W-1:0]   in_data,
	output logic                       push,
	output tah_pkg::item_t             push_item,
	input  tah_pkg::q_stat_t           q_stat
);

	localparam int RN = tah_pkg::ROOT_N;
	localparam int RW = tah_pkg::REM_W;

	logic en;
	logic signed [15:0] ax_in, ay_in, az_in;
	logic signed [31:0] pxx, pyy, pzz;

	logic        v_s1;
	logic [31:0] mx_s1, my_s1;
	logic [15:0] ax_s1, ay_s1;
	logic [31:0] sqx_s1, sqy_s1, sqz_s1;

	logic        v_sx   [0:RN];
	logic [31:0] mx_sx  [0:RN];
	logic [31:0] my_sx  [0:RN];
	logic [15:0] ax_sx  [0:RN];
	logic [15:0] ay_sx  [0:RN];
	logic [RW-1:0] rem_sx  [0:RN][0:1];
	logic [31:0]   root_sx [0:RN][0:1];
	logic [31:0]   rad_sx  [0:RN][0:1];

	assign en = !(v_sx[RN] && q_stat.full);
	assign in_ready = en;
	assign push = v_sx[RN] && !q_stat.full;

	assign ax_in = in_data[79:64];
	assign ay_in = in_data[95:80];
	assign az_in = in_data[111:96];
	assign pxx = ax_in * ax_in;
	assign pyy = ay_in * ay_in;
	assign pzz = az_in * az_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_sx[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_sx[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= in_data[31:0];
			my_s1 <= in_data[63:32];
			ax_s1 <= in_data[79:64];
			ay_s1 <= in_data[95:80];
			sqx_s1 <= pxx;
			sqy_s1 <= pyy;
			sqz_s1 <= pzz;
			mx_sx[0] <= mx_s1;
			my_sx[0] <= my_s1;
			ax_sx[0] <= ax_s1;
			ay_sx[0] <= ay_s1;
			// tilt x root uses y and z, tilt y root uses x and z
			rad_sx[0][0] <= sqy_s1 + sqz_s1;
			rad_sx[0][1] <= sqx_s1 + sqz_s1;
			rem_sx[0][0] <= '0;
			rem_sx[0][1] <= '0;
			root_sx[0][0] <= '0;
			root_sx[0][1] <= '0;
		end
	end

	for (genvar k = 0; k < RN; k++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sx[k+1] <= 1'b0;
			end else if (en) begin
				v_sx[k+1] <= v_sx[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mx_sx[k+1] <= mx_sx[k];
				my_sx[k+1] <= my_sx[k];
				ax_sx[k+1] <= ax_sx[k];
				ay_sx[k+1] <= ay_sx[k];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [RW-1:0] rem2, trial;

			always_comb begin
				rem2 = {rem_sx[k][l][RW-3:0], rad_sx[k][l][31:30]};
				trial = {{(RW-34){1'b0}}, root_sx[k][l], 2'b01};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rad_sx[k+1][l] <= {rad_sx[k][l][29:0], 2'b00};
					if (rem2 >= trial) begin
						rem_sx[k+1][l] <= rem2 - trial;
						root_sx[k+1][l] <= {root_sx[k][l][30:0], 1'b1};
					end else begin
						rem_sx[k+1][l] <= rem2;
						root_sx[k+1][l] <= {root_sx[k][l][30:0], 1'b0};
					end
				end
			end
		end
	end

	always_comb begin
		push_item[tah_pkg::LANE_HEAD].y = {my_sx[RN][31], my_sx[RN]};
		push_item[tah_pkg::LANE_HEAD].x = {mx_sx[RN][31], mx_sx[RN]};
		push_item[tah_pkg::LANE_TX].y = {ax_sx[RN][15], ax_sx[RN], 16'h0000};
		push_item[tah_pkg::LANE_TX].x = {1'b0, root_sx[RN][0]};
		push_item[tah_pkg::LANE_TY].y = {ay_sx[RN][15], ay_sx[RN], 16'h0000};
		push_item[tah_pkg::LANE_TY].x = {1'b0, root_sx[RN][1]};
	end

endmodule

[design/tah_fifo.sv]
// ----------------------------------------------------------------------------
// tah_fifo
// short queue of operand words between front and back
// ----------------------------------------------------------------------------
module tah_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tah_pkg::item_t    push_item,
	input  logic              pop,
	output tah_pkg::q_stat_t  q_stat,
	output tah_pkg::item_t    pop_item
);

	localparam int PW = tah_pkg::PTR_W;

	tah_pkg::item_t mem_q [0:tah_pkg::FIFO_DEPTH-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	assign q_stat.valid = (cnt_q != '0);
	assign q_stat.full = (cnt_q == (PW+1)'(tah_pkg::FIFO_DEPTH));
	assign pop_item = mem_q[rd_q];

endmodule

[design/tah_atan2.sv]
// ----------------------------------------------------------------------------
// tah_atan2
// pipelined atan2 lane: magnitudes, normalize, vectoring cordic, quadrant
// fix-up and truncation to whole degrees
// ----------------------------------------------------------------------------
module tah_atan2 (
	input  logic                 clk,
	input  logic                 en,
	input  tah_pkg::pair_t       op,
	output logic signed [8:0]    deg
);

	localparam int CW = tah_pkg::CW;
	localparam int ZW = tah_pkg::ZW;
	localparam int NN = tah_pkg::NORM_N;
	localparam int CN = tah_pkg::CORDIC_N;
	localparam int ZI = NN + CN;

	logic signed [CW-1:0] xe, ye;
	logic signed [CW-1:0] ux_sx [0:ZI];
	logic signed [CW-1:0] uy_sx [0:ZI];
	logic signed [ZW-1:0] z_sx  [0:ZI];
	tah_pkg::flags_t      fl_sx [0:ZI];
	logic signed [ZW-1:0] a;
	logic [7:0]           whole;

	assign xe = {{(CW-tah_pkg::OP_W){op.x[tah_pkg::OP_W-1]}}, op.x};
	assign ye = {{(CW-tah_pkg::OP_W){op.y[tah_pkg::OP_W-1]}}, op.y};

	always_ff @(posedge clk) begin
		if (en) begin
			ux_sx[0] <= xe[CW-1] ? -xe : xe;
			uy_sx[0] <= ye[CW-1] ? -ye : ye;
			z_sx[0] <= '0;
			fl_sx[0].yz <= (op.y == '0);
			fl_sx[0].xz <= (op.x == '0);
			fl_sx[0].xn <= op.x[tah_pkg::OP_W-1];
			fl_sx[0].yn <= op.y[tah_pkg::OP_W-1];
		end
	end

	for (genvar j = 0; j < NN; j++) begin : g_norm
		localparam int SH = 16 >> j;
		localparam logic [CW-1:0] THR = {{(CW-31){1'b0}}, 31'd1 << (30 - SH)};

		always_ff @(posedge clk) begin
			if (en) begin
				if ((ux_sx[j] | uy_sx[j]) < THR) begin
					ux_sx[j+1] <= ux_sx[j] <<< SH;
					uy_sx[j+1] <= uy_sx[j] <<< SH;
				end else begin
					ux_sx[j+1] <= ux_sx[j];
					uy_sx[j+1] <= uy_sx[j];
				end
				z_sx[j+1] <= z_sx[j];
				fl_sx[j+1] <= fl_sx[j];
			end
		end
	end

	for (genvar i = 0; i < CN; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] TAB = tah_pkg::atan_tab(i);
		localparam int K = NN + i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (uy_sx[K] > 0) begin
					ux_sx[K+1] <= ux_sx[K] + (uy_sx[K] >>> i);
					uy_sx[K+1] <= uy_sx[K] - (ux_sx[K] >>> i);
					z_sx[K+1] <= z_sx[K] + TAB;
				end else begin
					ux_sx[K+1] <= ux_sx[K] - (uy_sx[K] >>> i);
					uy_sx[K+1] <= uy_sx[K] + (ux_sx[K] >>> i);
					z_sx[K+1] <= z_sx[K] - TAB;
				end
				fl_sx[K+1] <= fl_sx[K];
			end
		end
	end

	always_comb begin
		a = z_sx[ZI];
		if (a < 0) a = '0;
		if (a > tah_pkg::DEG90) a = tah_pkg::DEG90;
		if (fl_sx[ZI].xn) a = tah_pkg::DEG180 - a;
		if (fl_sx[ZI].yz) begin
			a = fl_sx[ZI].xn ? tah_pkg::DEG180 : '0;
		end else if (fl_sx[ZI].xz) begin
			a = tah_pkg::DEG90;
		end
		whole = a[23:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg <= fl_sx[ZI].yn ? -$signed({1'b0, whole}) : $signed({1'b0, whole});
		end
	end

endmodule

[design/tah_back.sv]
// ----------------------------------------------------------------------------
// tah_back
// three atan2 lanes, heading wrap and tilt negation, output register
// ----------------------------------------------------------------------------
module tah_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tah_pkg::q_stat_t           q_stat,
	input  tah_pkg::item_t             q_item,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tah_pkg::OUT_W-1:0]  out_data
);

	localparam int LL = tah_pkg::LANE_LAT;

	logic en;
	logic v_q [0:LL-1];
	logic signed [8:0] deg [0:tah_pkg::LANES-1];
	logic [8:0] head;
	logic [7:0] tx, ty;

	assign en = !out_valid || out_ready;
	assign pop = q_stat.valid && en;

	for (genvar n = 0; n < tah_pkg::LANES; n++) begin : g_lane
		tah_atan2 u_lane (
			.clk (clk),
			.en  (en),
			.op  (q_item[n]),
			.deg (deg[n])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LL; k++) v_q[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_q[0] <= q_stat.valid;
			for (int k = 1; k < LL; k++) v_q[k] <= v_q[k-1];
			out_valid <= v_q[LL-1];
		end
	end

	always_comb begin
		head = deg[tah_pkg::LANE_HEAD][8] ? 9'(deg[tah_pkg::LANE_HEAD] + 9'sd360)
			: deg[tah_pkg::LANE_HEAD];
		tx = 8'(-deg[tah_pkg::LANE_TX]);
		ty = 8'(-deg[tah_pkg::LANE_TY]);
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= {7'b0, ty, tx, head};
	end

endmodule

[design/tilt_and_heading_angles.sv]
// from accepted sample word to result word, data passes the square and
// square-root pipeline, the queue, and the atan2 lanes and output register
// throughput one word per cycle while the output is not back-pressured,
// set by the fully pipelined root and cordic
// arst_n clears valid bits and queue pointers, data registers are not reset
// ----------------------------------------------------------------------------
// tilt_and_heading_angles
// compass heading and two tilt angles from one magnetometer and accel sample
// ----------------------------------------------------------------------------
module tilt_and_heading_angles (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// mag_x, mag_y, accel_x, accel_y, accel_z
	input  logic [tah_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// heading_deg, tilt_x_deg, tilt_y_deg, zero pad
	output logic [tah_pkg::OUT_W-1:0]  m_axis_tdata
);

	logic             push, pop;
	tah_pkg::item_t   push_item, pop_item;
	tah_pkg::q_stat_t q_stat;

	tah_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.push      (push),
		.push_item (push_item),
		.q_stat    (q_stat)
	);

	tah_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_stat    (q_stat),
		.pop_item  (pop_item)
	);

	tah_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_item    (pop_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

[design/tah_checker.sv]
// ----------------------------------------------------------------------------
// tah_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "tilt_and_heading_angles_assert.svh"

module tah_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	`TAH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`TAH_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`TAH_ASSERT_NOW(a_heading_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[8:0] < 9'd360)
	`TAH_ASSERT_NOW(a_tilt_range, clk, arst_n, m_axis_tvalid, ($signed(m_axis_tdata[16:9]) >= -8'sd90) && ($signed(m_axis_tdata[16:9]) <= 8'sd90) && ($signed(m_axis_tdata[24:17]) >= -8'sd90) && ($signed(m_axis_tdata[24:17]) <= 8'sd90))

endmodule

bind tilt_and_heading_angles tah_port_checker u_tah_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
